/* rtl/dpmt_pkg.sv */
package dpmt_pkg;

    // Payload widths
    localparam int unsigned SelW     = 2;
    localparam int unsigned MinutesW = 16;
    localparam int unsigned HoursW   = 11;
    localparam int unsigned MinLeftW = 6;
    localparam int unsigned QuenchW  = 16;
    localparam int unsigned TenthW   = 4;
    localparam int unsigned SecW     = 6;
    localparam int unsigned CodeW    = 2;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 56;
    localparam int unsigned CfgIdxW  = 8;

    // Counter end values
    localparam logic [TenthW-1:0] TenthLast  = 4'd9;
    localparam logic [SecW-1:0]   SecondLast = 6'd59;

    // Reciprocal of sixty: floor(x * 34953 / 2^21) == x / 60 for every 16-bit x
    localparam logic [15:0] Div60Mult  = 16'd34953;
    localparam int unsigned Div60Shift = 21;

    // Sequence selector and completion codes
    localparam logic [SelW-1:0]  SelSeq1  = 2'd1;
    localparam logic [SelW-1:0]  SelSeq2  = 2'd2;
    localparam logic [CodeW-1:0] CodeSeq1 = 2'd1;
    localparam logic [CodeW-1:0] CodeSeq2 = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgTotalSeq1 = 8'd0;
    localparam logic [CfgIdxW-1:0] CfgTotalSeq2 = 8'd1;

    // State snapshot handed from the counter stage to the output stage
    typedef struct packed {
        logic                second;
        logic [CodeW-1:0]    code;
        logic [MinutesW-1:0] rem1;
        logic [MinutesW-1:0] rem2;
        logic [QuenchW-1:0]  quench;
    } snap_t;

endpackage

/* rtl/dpmt_core.sv */
module dpmt_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpmt_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [dpmt_pkg::MinutesW-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dpmt_pkg::InDataW-1:0]   s_tdata,
    output logic                           snap_valid,
    input  logic                           snap_ready,
    output dpmt_pkg::snap_t                snap
);
    import dpmt_pkg::*;

    logic [MinutesW-1:0] total1_reg, total2_reg;
    logic [TenthW-1:0]   tenth_reg, tenth_next;
    logic [SecW-1:0]     sec1_reg, sec1_next, sec2_reg, sec2_next;
    logic [MinutesW-1:0] done1_reg, done1_next, done2_reg, done2_next;
    logic [CodeW-1:0]    code_reg, code_next;
    logic [MinutesW-1:0] rem1_reg, rem1_next, rem2_reg, rem2_next;
    logic [QuenchW-1:0]  quench_reg, quench_next;
    logic                second_reg, valid_reg, valid_next;
    logic                accept, tick, count1, count2;
    logic [SelW-1:0]     sel;
    logic                hold, quench_run;
    logic [MinutesW:0]   inc1, inc2;

    assign sel        = s_tdata[1:0];
    assign hold       = s_tdata[2];
    assign quench_run = s_tdata[3];

    assign cfg_ready = 1'b1;
    assign s_tready  = !valid_reg || snap_ready;
    assign accept    = s_tvalid && s_tready;
    assign tick      = (tenth_reg == TenthLast);
    assign count1    = tick && !hold && (sel == SelSeq1);
    assign count2    = tick && !hold && (sel == SelSeq2);
    assign inc1      = {1'b0, done1_reg} + {{MinutesW{1'b0}}, 1'b1};
    assign inc2      = {1'b0, done2_reg} + {{MinutesW{1'b0}}, 1'b1};

    // Advance the tenth, second, minute and quench counters per tick
    always_comb begin
        tenth_next  = tick ? '0 : tenth_reg + 1'b1;
        sec1_next   = sec1_reg;
        sec2_next   = sec2_reg;
        done1_next  = done1_reg;
        done2_next  = done2_reg;
        code_next   = code_reg;
        quench_next = quench_reg;
        if (count1) begin
            if (sec1_reg == SecondLast) begin
                sec1_next = '0;
                if (inc1 >= {1'b0, total1_reg}) begin
                    done1_next = total1_reg;
                    code_next  = CodeSeq1;
                end else begin
                    done1_next = inc1[MinutesW-1:0];
                end
            end else begin
                sec1_next = sec1_reg + 1'b1;
            end
        end
        if (count2) begin
            if (sec2_reg == SecondLast) begin
                sec2_next = '0;
                if (inc2 >= {1'b0, total2_reg}) begin
                    done2_next = total2_reg;
                    code_next  = CodeSeq2;
                end else begin
                    done2_next = inc2[MinutesW-1:0];
                end
            end else begin
                sec2_next = sec2_reg + 1'b1;
            end
        end
        if (tick && quench_run) begin
            quench_next = quench_reg + 1'b1;
        end
    end

    // Refresh the remaining time on each second only
    assign rem1_next = tick ? total1_reg - done1_next : rem1_reg;
    assign rem2_next = tick ? total2_reg - done2_next : rem2_reg;

    // Hold the snapshot valid until the output stage takes it
    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (snap_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total1_reg <= '0;
            total2_reg <= '0;
            tenth_reg  <= '0;
            sec1_reg   <= '0;
            sec2_reg   <= '0;
            done1_reg  <= '0;
            done2_reg  <= '0;
            code_reg   <= '0;
            rem1_reg   <= '0;
            rem2_reg   <= '0;
            quench_reg <= '0;
            second_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CfgTotalSeq1) begin
                    total1_reg <= cfg_data;
                end else if (cfg_index == CfgTotalSeq2) begin
                    total2_reg <= cfg_data;
                end
            end
            if (accept) begin
                tenth_reg  <= tenth_next;
                sec1_reg   <= sec1_next;
                sec2_reg   <= sec2_next;
                done1_reg  <= done1_next;
                done2_reg  <= done2_next;
                code_reg   <= code_next;
                rem1_reg   <= rem1_next;
                rem2_reg   <= rem2_next;
                quench_reg <= quench_next;
                second_reg <= tick;
            end
        end
    end

    assign snap_valid  = valid_reg;
    assign snap.second = second_reg;
    assign snap.code   = code_reg;
    assign snap.rem1   = rem1_reg;
    assign snap.rem2   = rem2_reg;
    assign snap.quench = quench_reg;

    // A beat that completed a second leaves the tenth counter at zero
    a_second_wraps_tenth: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && second_reg |-> tenth_reg == '0)
        else $error("second flagged but tenth counter not wrapped");

    a_tenth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tenth_reg <= TenthLast)
        else $error("tenth counter out of range");

    a_seconds_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sec1_reg <= SecondLast && sec2_reg <= SecondLast)
        else $error("sequence seconds out of range");

    a_code_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        code_reg == '0 || code_reg == CodeSeq1 || code_reg == CodeSeq2)
        else $error("illegal completion code");

endmodule

/* rtl/dpmt_out.sv */
module dpmt_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          snap_valid,
    output logic                          snap_ready,
    input  dpmt_pkg::snap_t               snap,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dpmt_pkg::OutDataW-1:0] m_tdata
);
    import dpmt_pkg::*;

    localparam int unsigned ProdW = 2 * MinutesW;

    logic                valid_reg, valid_next;
    logic [OutDataW-1:0] data_reg, data_next;
    logic [HoursW-1:0]   hours1, hours2;
    logic [MinLeftW-1:0] mins1, mins2;

    // Split minutes into hours and minutes past the hour
    function automatic logic [HoursW+MinLeftW-1:0] split_hours(input logic [MinutesW-1:0] x);
        logic [ProdW-1:0]    prod;
        logic [HoursW-1:0]   q;
        logic [MinutesW-1:0] q60;
        logic [MinutesW-1:0] r;
        prod = ProdW'(x) * ProdW'(Div60Mult);
        q    = prod[Div60Shift +: HoursW];
        q60  = {q[HoursW-2:0], 6'b0} - {{(MinutesW-HoursW-2){1'b0}}, q, 2'b0};
        r    = x - q60;
        return {q, r[MinLeftW-1:0]};
    endfunction

    assign {hours1, mins1} = split_hours(snap.rem1);
    assign {hours2, mins2} = split_hours(snap.rem2);

    assign data_next = {3'b0, snap.quench, mins2, hours2, mins1, hours1, snap.code, snap.second};

    assign snap_ready = !valid_reg || m_tready;

    // Hold the result until the receiver takes it
    always_comb begin
        if (snap_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (snap_ready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_valid && snap_ready) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    // Minutes past the hour never reach sixty
    a_minutes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> data_reg[19:14] < 6'd60 && data_reg[36:31] < 6'd60)
        else $error("minutes left out of range");

    // A stalled result keeps its contents
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_tready |=> $stable(data_reg))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> snap_ready)
        else $error("output stage empty but not ready");

endmodule

/* rtl/dual_process_minute_timer.sv */
// Dual process minute timer.
// Each beat on the s_ channel is one 100 ms tick carrying the active sequence
// selector, the hold flag and the quench-running flag. Every tick gives one
// result beat on the m_ channel: second flag, latched completion code,
// remaining hours and minutes of both sequences and the quench seconds.
// Sequence totals are written over the cfg channel (index 0: sequence one,
// index 1: sequence two, 16-bit minutes); cfg_ready is always high.
// A tick is registered in the counter stage and then in the output stage,
// whose register raises m_tvalid with its result.
// Throughput is one tick per cycle while m_tready stays high:
// a counter stage updates all state and a second register stage splits the
// remaining minutes into hours and minutes by a reciprocal multiply.
// When the receiver stalls, both stages fill and s_tready drops; nothing is
// lost and a held result keeps its value. Reset (aresetn low at a clock edge)
// clears every counter, the totals and the completion code and empties both
// stages; no clearing pass is needed.
module dual_process_minute_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] active_sequence, [2] hold, [3] quench_running, [7:4] zero
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] second_elapsed, [2:1] complete_code, [13:3] seq1_hours_left,
    // [19:14] seq1_minutes_left, [30:20] seq2_hours_left,
    // [36:31] seq2_minutes_left, [52:37] quench_seconds, [55:53] zero
    output logic [55:0] m_tdata
);
    import dpmt_pkg::*;

    snap_t snap;
    logic  snap_valid, snap_ready;

    dpmt_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    dpmt_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
